FILE: hw/rtl/pcg_pkg.sv
package pcg_pkg;

	localparam int unsigned StateWidth  = 64;
	localparam int unsigned ValueWidth  = 32;
	localparam int unsigned StreamWidth = 63;
	localparam int unsigned CfgIdxWidth = 2;
	localparam int unsigned HalfWidth   = StateWidth / 2;

	localparam logic [StateWidth-1:0] LcgMult = 64'd6364136223846793005;

	localparam int unsigned XsShift   = 18;
	localparam int unsigned XsDrop    = 27;
	localparam int unsigned RotTop    = 59;

	typedef enum logic [1:0] {
		OpNext   = 2'd0,
		OpJump   = 2'd1,
		OpReseed = 2'd2
	} op_t;

	localparam logic [CfgIdxWidth-1:0] RegSeed   = 2'd0;
	localparam logic [CfgIdxWidth-1:0] RegStream = 2'd1;

	// multiply-add request: result = a * b + c (mod 2^64)
	typedef struct packed {
		logic                  start;
		logic [StateWidth-1:0] a;
		logic [StateWidth-1:0] b;
		logic [StateWidth-1:0] c;
	} mul_req_t;

	typedef struct packed {
		logic                  done;
		logic [StateWidth-1:0] result;
	} mul_rsp_t;

	// xorshift high, then rotate right by the top five state bits
	function automatic logic [ValueWidth-1:0] permute(input logic [StateWidth-1:0] s);
		logic [StateWidth-1:0] xs;
		logic [ValueWidth-1:0] x;
		logic [4:0]            r;
		logic [2*ValueWidth-1:0] rr;
		xs = (s >> XsShift) ^ s;
		x  = xs[XsDrop +: ValueWidth];
		r  = s[RotTop +: 5];
		rr = {x, x} >> r;
		return rr[ValueWidth-1:0];
	endfunction

endpackage

FILE: hw/rtl/pcg32_generator_with_jump.sv
// PCG-XSH-RR generator with 64-bit LCG state and jump-ahead. Every multiply goes
// through one shared 32x32 multiplier that builds a 64-bit product from partial products,
// so items are taken one at a time and in_stall is high while one is at work.
// Next runs one multiply, updates the state, then raises the output word and returns
// to idle, waiting first while the output register is still stalled; reseed runs
// one multiply.
// Jump checks the distance one bit at a time and runs two multiplies for every bit up
// to its highest set bit and two more for each set bit, plus one final multiply.
// Operation 3 is dropped with no output.
module pcg32_generator_with_jump (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pcg_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  logic [pcg_pkg::StateWidth-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         operation,
	input  logic [pcg_pkg::StateWidth-1:0]     jump_distance,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pcg_pkg::ValueWidth-1:0]     random_value
);

	localparam int unsigned W  = pcg_pkg::StateWidth;
	localparam int unsigned SW = pcg_pkg::StreamWidth;

	typedef enum logic [3:0] {
		StIdle,
		StNext,
		StEmit,
		StReseed,
		StJCheck,
		StJAccM,
		StJAccC,
		StJCurC,
		StJCurM,
		StJFinal
	} state_t;

	state_t state_q;

	logic [W-1:0]  lcg_state_q;
	logic [W-1:0]  lcg_inc_q;
	logic [W-1:0]  seed_q;
	logic [SW-1:0] stream_q;

	logic [W-1:0]  dist_q;
	logic [W-1:0]  accm_q;
	logic [W-1:0]  accc_q;
	logic [W-1:0]  curm_q;
	logic [W-1:0]  curc_q;
	logic [pcg_pkg::ValueWidth-1:0] perm_q;

	logic                           out_valid_q;
	logic [pcg_pkg::ValueWidth-1:0] random_value_q;

	logic         mul_start_q;
	logic [W-1:0] mul_a_q;
	logic [W-1:0] mul_b_q;
	logic [W-1:0] mul_c_q;

	pcg_pkg::mul_req_t mul_req;
	pcg_pkg::mul_rsp_t mul_rsp;

	logic         in_acc;
	logic         out_free;
	logic [W-1:0] new_inc;

	assign mul_req = '{start: mul_start_q, a: mul_a_q, b: mul_b_q, c: mul_c_q};

	pcg_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign in_stall = (state_q != StIdle);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign new_inc  = {stream_q, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			stream_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pcg_pkg::RegSeed:   seed_q   <= cfg_data;
				pcg_pkg::RegStream: stream_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			lcg_state_q <= '0;
			lcg_inc_q   <= W'(1);
			out_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (in_acc) begin
						case (operation)
							pcg_pkg::OpNext: begin
								mul_start_q <= 1'b1;
								state_q     <= StNext;
							end
							pcg_pkg::OpJump: state_q <= StJCheck;
							pcg_pkg::OpReseed: begin
								lcg_inc_q   <= new_inc;
								mul_start_q <= 1'b1;
								state_q     <= StReseed;
							end
							default: ;
						endcase
					end
				end
				StNext: begin
					if (mul_rsp.done) begin
						lcg_state_q <= mul_rsp.result;
						state_q     <= StEmit;
					end
				end
				StEmit: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= StIdle;
					end
				end
				StReseed: begin
					if (mul_rsp.done) begin
						lcg_state_q <= mul_rsp.result;
						state_q     <= StIdle;
					end
				end
				StJCheck: begin
					mul_start_q <= 1'b1;
					if (dist_q == '0) state_q <= StJFinal;
					else if (dist_q[0]) state_q <= StJAccM;
					else state_q <= StJCurC;
				end
				StJAccM: begin
					if (mul_rsp.done) begin
						mul_start_q <= 1'b1;
						state_q     <= StJAccC;
					end
				end
				StJAccC: begin
					if (mul_rsp.done) begin
						mul_start_q <= 1'b1;
						state_q     <= StJCurC;
					end
				end
				StJCurC: begin
					if (mul_rsp.done) begin
						mul_start_q <= 1'b1;
						state_q     <= StJCurM;
					end
				end
				StJCurM: begin
					if (mul_rsp.done) state_q <= StJCheck;
				end
				StJFinal: begin
					if (mul_rsp.done) begin
						lcg_state_q <= mul_rsp.result;
						state_q     <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// datapath registers and multiplier operands
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				if (in_acc) begin
					perm_q   <= pcg_pkg::permute(lcg_state_q);
					dist_q   <= jump_distance;
					accm_q   <= W'(1);
					accc_q   <= '0;
					curm_q   <= pcg_pkg::LcgMult;
					curc_q   <= lcg_inc_q;
					if (operation == pcg_pkg::OpReseed) begin
						mul_a_q <= new_inc + seed_q;
						mul_b_q <= pcg_pkg::LcgMult;
						mul_c_q <= new_inc;
					end else begin
						mul_a_q <= lcg_state_q;
						mul_b_q <= pcg_pkg::LcgMult;
						mul_c_q <= lcg_inc_q;
					end
				end
			end
			StEmit: begin
				if (out_free) random_value_q <= perm_q;
			end
			StJCheck: begin
				if (dist_q == '0) begin
					mul_a_q <= accm_q;
					mul_b_q <= lcg_state_q;
					mul_c_q <= accc_q;
				end else if (dist_q[0]) begin
					mul_a_q <= accm_q;
					mul_b_q <= curm_q;
					mul_c_q <= '0;
				end else begin
					mul_a_q <= curm_q + W'(1);
					mul_b_q <= curc_q;
					mul_c_q <= '0;
				end
			end
			StJAccM: begin
				if (mul_rsp.done) begin
					accm_q  <= mul_rsp.result;
					mul_a_q <= accc_q;
					mul_b_q <= curm_q;
					mul_c_q <= curc_q;
				end
			end
			StJAccC: begin
				if (mul_rsp.done) begin
					accc_q  <= mul_rsp.result;
					mul_a_q <= curm_q + W'(1);
					mul_b_q <= curc_q;
					mul_c_q <= '0;
				end
			end
			StJCurC: begin
				if (mul_rsp.done) begin
					curc_q  <= mul_rsp.result;
					mul_a_q <= curm_q;
					mul_b_q <= curm_q;
					mul_c_q <= '0;
				end
			end
			StJCurM: begin
				if (mul_rsp.done) begin
					curm_q <= mul_rsp.result;
					dist_q <= dist_q >> 1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign random_value = random_value_q;

endmodule

FILE: hw/rtl/pcg_mul64.sv
module pcg_mul64 (
	input  logic              clk,
	input  logic              arst_n,
	input  pcg_pkg::mul_req_t req,
	output pcg_pkg::mul_rsp_t rsp
);

	localparam int unsigned W = pcg_pkg::StateWidth;
	localparam int unsigned H = pcg_pkg::HalfWidth;

	logic [1:0]   step_q;
	logic         done_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] prod_q;
	logic [H-1:0] op_x;
	logic [H-1:0] op_y;
	logic [W-1:0] prod;

	// partial products: lo*lo, lo*hi, hi*lo; hi*hi falls outside 64 bits
	always_comb begin
		case (step_q)
			2'd1: begin
				op_x = req.a[H-1:0];
				op_y = req.b[W-1:H];
			end
			2'd2: begin
				op_x = req.a[W-1:H];
				op_y = req.b[H-1:0];
			end
			default: begin
				op_x = req.a[H-1:0];
				op_y = req.b[H-1:0];
			end
		endcase
	end

	assign prod = op_x * op_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				2'd0: if (req.start) step_q <= 2'd1;
				2'd1: step_q <= 2'd2;
				2'd2: step_q <= 2'd3;
				default: begin
					step_q <= 2'd0;
					done_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			2'd0: begin
				acc_q  <= req.c;
				prod_q <= prod;
			end
			2'd1: begin
				acc_q  <= acc_q + prod_q;
				prod_q <= prod;
			end
			2'd2: begin
				acc_q  <= acc_q + {prod_q[H-1:0], {H{1'b0}}};
				prod_q <= prod;
			end
			default: begin
				acc_q  <= acc_q + {prod_q[H-1:0], {H{1'b0}}};
			end
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule

FILE: hw/rtl/pcg_checker.sv
module pcg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [1:0]                     operation,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [pcg_pkg::ValueWidth-1:0] random_value
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_value))
		else $error("output word changed while stalled");

	// a real operation keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == pcg_pkg::OpNext ||
		operation == pcg_pkg::OpJump || operation == pcg_pkg::OpReseed) |=> in_stall)
		else $error("block not busy after accepting an operation");

	// a new word only appears after the block was busy
	a_word_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output word appeared without work");

	// an idle block cannot deliver a word in the very next cycle
	a_no_word_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("output word produced while idle");

endmodule

bind pcg32_generator_with_jump pcg_checker u_pcg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.operation    (operation),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.random_value (random_value)
);
